// ----- src/ime_pkg.sv -----
`timescale 1ns / 1ps

package ime_pkg;

    localparam int MAX_RANGES_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int ENTRY_W        = 2 * DATA_W;
    localparam int PADDR_W        = 3;

    // word index within the register space (byte address bit 2)
    localparam logic REG_MIN_SEP = 1'b0;

    localparam logic FUNC_ADD     = 1'b0;
    localparam logic FUNC_RESOLVE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED   = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_MERGED  = 2'd2,
        KIND_EMPTY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RD_I      = 2'd0,
        RD_J_PREV = 2'd1,
        RD_ZERO   = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_ADD   = 2'd0,
        WR_SHIFT = 2'd1,
        WR_KEY   = 2'd2,
        WR_CUR   = 2'd3
    } t_wr_sel;

    typedef struct packed {
        logic    capture;
        t_rd_sel rd_sel;
        logic    we;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_from_m;
        logic    key_load;
        logic    j_load;
        logic    j_dec;
        logic    i_one;
        logic    i_inc;
        logic    m_clear;
        logic    m_inc;
        logic    cur_load;
        logic    cur_widen;
        logic    emit;
        t_kind   emit_kind;
        logic    emit_last;
    } t_cmd;

    typedef struct packed {
        logic func_resolve;
        logic cnt_full;
        logic cnt_zero;
        logic i_done;
        logic j_one;
        logic key_before;
        logic merge_hit;
        logic out_free;
    } t_stat;

endpackage

// ----- src/ime_ctrl.sv -----
`timescale 1ns / 1ps

module ime_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ime_pkg::t_stat i_stat,
    output ime_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_DISP      = 12'b000000000010,
        S_SORT_CHK  = 12'b000000000100,
        S_SORT_KEY  = 12'b000000001000,
        S_SORT_RD   = 12'b000000010000,
        S_SORT_CMP  = 12'b000000100000,
        S_SORT_PUT  = 12'b000001000000,
        S_MRG_INIT  = 12'b000010000000,
        S_MRG_FIRST = 12'b000100000000,
        S_MRG_CHK   = 12'b001000000000,
        S_MRG_CMP   = 12'b010000000000,
        S_MRG_END   = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_sel     = ime_pkg::RD_I;
        o_cmd.wr_sel     = ime_pkg::WR_ADD;
        o_cmd.emit_kind  = ime_pkg::KIND_ADDED;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_stat.func_resolve) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        if (i_stat.cnt_full) begin
                            o_cmd.emit_kind = ime_pkg::KIND_DROPPED;
                        end else begin
                            o_cmd.emit_kind = ime_pkg::KIND_ADDED;
                            o_cmd.we        = 1'b1;
                            o_cmd.wr_sel    = ime_pkg::WR_ADD;
                            o_cmd.cnt_inc   = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else if (i_stat.cnt_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_kind = ime_pkg::KIND_EMPTY;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.i_one = 1'b1;
                    n_state     = S_SORT_CHK;
                end
            end
            // insertion sort: fetch entry i as the key, walk down shifting larger entries
            S_SORT_CHK: begin
                o_cmd.rd_sel = ime_pkg::RD_I;
                n_state      = i_stat.i_done ? S_MRG_INIT : S_SORT_KEY;
            end
            S_SORT_KEY: begin
                o_cmd.key_load = 1'b1;
                o_cmd.j_load   = 1'b1;
                n_state        = S_SORT_RD;
            end
            S_SORT_RD: begin
                o_cmd.rd_sel = ime_pkg::RD_J_PREV;
                n_state      = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (i_stat.key_before) begin
                    o_cmd.we     = 1'b1;
                    o_cmd.wr_sel = ime_pkg::WR_SHIFT;
                    o_cmd.j_dec  = 1'b1;
                    n_state      = i_stat.j_one ? S_SORT_PUT : S_SORT_RD;
                end else begin
                    n_state = S_SORT_PUT;
                end
            end
            S_SORT_PUT: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_sel = ime_pkg::WR_KEY;
                o_cmd.i_inc  = 1'b1;
                n_state      = S_SORT_CHK;
            end
            // merge scan: running range in cur, closed ranges written back at m
            S_MRG_INIT: begin
                o_cmd.rd_sel = ime_pkg::RD_ZERO;
                n_state      = S_MRG_FIRST;
            end
            S_MRG_FIRST: begin
                o_cmd.cur_load = 1'b1;
                o_cmd.m_clear  = 1'b1;
                o_cmd.i_one    = 1'b1;
                n_state        = S_MRG_CHK;
            end
            S_MRG_CHK: begin
                o_cmd.rd_sel = ime_pkg::RD_I;
                n_state      = i_stat.i_done ? S_MRG_END : S_MRG_CMP;
            end
            S_MRG_CMP: begin
                o_cmd.rd_sel = ime_pkg::RD_I;
                if (i_stat.merge_hit) begin
                    o_cmd.cur_widen = 1'b1;
                    o_cmd.i_inc     = 1'b1;
                    n_state         = S_MRG_CHK;
                end else if (i_stat.out_free) begin
                    o_cmd.we        = 1'b1;
                    o_cmd.wr_sel    = ime_pkg::WR_CUR;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = ime_pkg::KIND_MERGED;
                    o_cmd.m_inc     = 1'b1;
                    o_cmd.cur_load  = 1'b1;
                    o_cmd.i_inc     = 1'b1;
                    n_state         = S_MRG_CHK;
                end
            end
            S_MRG_END: begin
                if (i_stat.out_free) begin
                    o_cmd.we         = 1'b1;
                    o_cmd.wr_sel     = ime_pkg::WR_CUR;
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_kind  = ime_pkg::KIND_MERGED;
                    o_cmd.emit_last  = 1'b1;
                    o_cmd.cnt_from_m = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ime_datapath.sv -----
`timescale 1ns / 1ps

module ime_datapath #(
    parameter int MAX_RANGES = ime_pkg::MAX_RANGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ime_pkg::t_cmd               i_cmd,
    output ime_pkg::t_stat              o_stat,
    input  logic signed [ime_pkg::DATA_W-1:0] i_min_sep,
    input  logic                        i_func,
    input  logic signed [ime_pkg::DATA_W-1:0] i_range_low,
    input  logic signed [ime_pkg::DATA_W-1:0] i_range_high,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_kind,
    output logic signed [ime_pkg::DATA_W-1:0] o_out_low,
    output logic signed [ime_pkg::DATA_W-1:0] o_out_high,
    output logic                        o_last
);

    localparam int DW = ime_pkg::DATA_W;
    localparam int EW = ime_pkg::ENTRY_W;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    // entry layout: low bound in the upper half, high bound in the lower half
    logic [EW-1:0] r_mem [MAX_RANGES];
    logic [EW-1:0] r_rdata;

    logic          r_func;
    logic [DW-1:0] r_add_low;
    logic [DW-1:0] r_add_high;
    logic [EW-1:0] r_key;
    logic [DW-1:0] r_cur_low;
    logic [DW-1:0] r_cur_high;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_m;

    logic          r_out_valid;
    ime_pkg::t_kind r_kind;
    logic [DW-1:0] r_out_low;
    logic [DW-1:0] r_out_high;
    logic          r_last;

    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic [DW-1:0] w_rd_low;
    logic [DW-1:0] w_rd_high;
    logic [DW-1:0] w_key_low;
    logic [DW-1:0] w_key_high;
    logic [DW:0]   w_diff;
    logic          w_out_free;

    assign w_rd_low   = r_rdata[EW-1:DW];
    assign w_rd_high  = r_rdata[DW-1:0];
    assign w_key_low  = r_key[EW-1:DW];
    assign w_key_high = r_key[DW-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            ime_pkg::RD_I:      w_rd_addr = r_i[IW-1:0];
            ime_pkg::RD_J_PREV: w_rd_addr = r_j - IW'(1);
            ime_pkg::RD_ZERO:   w_rd_addr = '0;
            default:            w_rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            ime_pkg::WR_ADD: begin
                w_wr_addr = r_cnt[IW-1:0];
                w_wr_data = {r_add_low, r_add_high};
            end
            ime_pkg::WR_SHIFT: begin
                w_wr_addr = r_j;
                w_wr_data = r_rdata;
            end
            ime_pkg::WR_KEY: begin
                w_wr_addr = r_j;
                w_wr_data = r_key;
            end
            ime_pkg::WR_CUR: begin
                w_wr_addr = r_m;
                w_wr_data = {r_cur_low, r_cur_high};
            end
            default: begin
                w_wr_addr = r_m;
                w_wr_data = {r_cur_low, r_cur_high};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // exact next low minus separation, one bit wider so it cannot wrap
    assign w_diff = {w_rd_low[DW-1], w_rd_low} - {i_min_sep[DW-1], i_min_sep};

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.func_resolve = (r_func == ime_pkg::FUNC_RESOLVE);
        o_stat.cnt_full     = (r_cnt == CW'(MAX_RANGES));
        o_stat.cnt_zero     = (r_cnt == '0);
        o_stat.i_done       = (r_i >= r_cnt);
        o_stat.j_one        = (r_j == IW'(1));
        o_stat.key_before   = (w_key_low == w_rd_low)
                            ? ($signed(w_key_high) < $signed(w_rd_high))
                            : ($signed(w_key_low) < $signed(w_rd_low));
        o_stat.merge_hit    = ($signed(w_diff) <= $signed({r_cur_high[DW-1], r_cur_high}));
        o_stat.out_free     = w_out_free;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_add_low  <= i_range_low;
            r_add_high <= i_range_high;
        end
        if (i_cmd.key_load) begin
            r_key <= r_rdata;
        end
        if (i_cmd.cur_load) begin
            r_cur_low  <= w_rd_low;
            r_cur_high <= w_rd_high;
        end else if (i_cmd.cur_widen && ($signed(w_rd_high) > $signed(r_cur_high))) begin
            r_cur_high <= w_rd_high;
        end
        if (i_cmd.j_load) begin
            r_j <= r_i[IW-1:0];
        end else if (i_cmd.j_dec) begin
            r_j <= r_j - IW'(1);
        end
        if (i_cmd.i_one) begin
            r_i <= CW'(1);
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.m_clear) begin
            r_m <= '0;
        end else if (i_cmd.m_inc) begin
            r_m <= r_m + IW'(1);
        end
        if (i_cmd.emit) begin
            r_kind <= i_cmd.emit_kind;
            r_last <= i_cmd.emit_last;
            if (i_cmd.emit_kind == ime_pkg::KIND_MERGED) begin
                r_out_low  <= r_cur_low;
                r_out_high <= r_cur_high;
            end else begin
                r_out_low  <= '0;
                r_out_high <= '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func      <= ime_pkg::FUNC_ADD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_func <= i_func;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_from_m) begin
                r_cnt <= CW'(r_m) + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_low   = r_out_low;
    assign o_out_high  = r_out_high;
    assign o_last      = r_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result overwrites a request still waiting");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind != ime_pkg::KIND_MERGED)) |-> r_last)
        else $error("add or empty result without last");

    a_merge_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.we && (i_cmd.wr_sel == ime_pkg::WR_CUR)) |-> (CW'(r_m) < r_i))
        else $error("merge write-back not behind the scan");

endmodule

// ----- src/interval_merge_engine.sv -----
// add request: result registered from S_DISP after acceptance; the next request is accepted
// once the controller is back in S_IDLE, later while a result waits; one request at a time
// resolve of n entries: insertion sort (a read state and a compare state per shift),
// then a merge scan, one range emitted per group
// both passes are bound by the single read port of the entry memory
// synchronous active-low reset empties the list and clears min_separation;
// entry contents are not cleared
`timescale 1ns / 1ps

module interval_merge_engine #(
    parameter int MAX_RANGES = ime_pkg::MAX_RANGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic signed [ime_pkg::DATA_W-1:0]  i_range_low,
    input  logic signed [ime_pkg::DATA_W-1:0]  i_range_high,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_kind,
    output logic signed [ime_pkg::DATA_W-1:0]  o_out_low,
    output logic signed [ime_pkg::DATA_W-1:0]  o_out_high,
    output logic                               o_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ime_pkg::PADDR_W-1:0]        paddr,
    input  logic [ime_pkg::DATA_W-1:0]         pwdata,
    output logic [ime_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic [ime_pkg::DATA_W-1:0] r_min_sep;
    ime_pkg::t_cmd              w_cmd;
    ime_pkg::t_stat             w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sep <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == ime_pkg::REG_MIN_SEP)) begin
            r_min_sep <= pwdata;
        end
    end

    assign prdata = (paddr[2] == ime_pkg::REG_MIN_SEP) ? r_min_sep : '0;

    ime_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ime_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_min_sep    (r_min_sep),
        .i_func       (i_func),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high),
        .o_last       (o_last)
    );

endmodule
